// ===== design/itsm_pkg.sv =====
// Shared codes and types for the interpolating table with suffix-max bound.
package itsm_pkg;

  // Request opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_VALUE = 2'd1;
  localparam logic [1:0] OP_BOUND = 2'd2;

  // Interpolation modes (any other code is linear)
  localparam logic [1:0] MODE_HOLD_RIGHT = 2'd1;
  localparam logic [1:0] MODE_HOLD_LEFT  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_BORDER   = 3'd1;
  localparam logic [2:0] REG_START    = 3'd2;
  localparam logic [2:0] REG_STEP     = 3'd3;
  localparam logic [2:0] REG_END      = 3'd4;
  localparam logic [2:0] REG_COUNT    = 3'd5;
  localparam logic [2:0] REG_CONSTANT = 3'd6;

  // Divider runs one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 33;

  // Sequencer states
  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_DEC   = 17'h00002,
    S_CLS   = 17'h00004,
    S_RBRD  = 17'h00008,
    S_RBWR  = 17'h00010,
    S_DIV   = 17'h00020,
    S_CLAMP = 17'h00040,
    S_FRAC  = 17'h00080,
    S_RDL   = 17'h00100,
    S_RDR   = 17'h00200,
    S_RDW   = 17'h00400,
    S_MODE  = 17'h00800,
    S_MULR  = 17'h01000,
    S_MDIV  = 17'h02000,
    S_MULQ  = 17'h04000,
    S_SUM   = 17'h08000,
    S_OUT   = 17'h10000
  } state_t;

endpackage

// ===== design/interpolating_table_with_suffix_max.sv =====
// Uniform-grid lookup table with interpolation and a suffix-max bound store.
//
// Channels: in_* carries one request (load, value query, future-bound query),
// out_* returns one result per request (0 for loads), cfg_* writes the
// registers by index. All use valid/ready; cfg_ready is always high.
// A load goes straight to its result. A query that falls outside the grid
// is answered without a division. An in-grid query runs a bit-serial divider
// for the cell index; the hold modes then read two samples and finish,
// linear mode adds a second division for the fraction, and a query past
// the last cell adds a fraction step and, in linear mode, one more division.
// The first future-bound query after a load or register write first
// rebuilds the suffix-max memory walking backward over each sample in
// use. Throughput is one request at a time; the next request is accepted as
// soon as the current result sits in the output register, even if the
// receiver has not taken it yet, and a finished result waits for that
// register to drain when the receiver stalls.
// Reset (synchronous, active low) restores the register defaults, empties
// the output and marks the suffix store stale; memory contents are kept
// and are undefined until written.
module interpolating_table_with_suffix_max
  import itsm_pkg::*;
#(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [9:0]         in_index,
  input  logic signed [31:0] in_sample,
  input  logic [31:0]        in_time_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Registers
  state_t             state_r;
  logic               out_valid_r;
  logic signed [31:0] out_result_r;
  logic               ready_r;
  logic [1:0]         mode_r;
  logic signed [31:0] border_r;
  logic [31:0]        start_r;
  logic [31:0]        step_r;
  logic [31:0]        end_r;
  logic [10:0]        count_r;
  logic               const_r;

  // Datapath registers
  logic [1:0]         op_r;
  logic [31:0]        t_r;
  logic [31:0]        off_r;
  logic [AW-1:0]      k_r;
  logic [AW-1:0]      i_r;
  logic signed [31:0] run_r;
  logic signed [31:0] sfx0_r;
  logic signed [31:0] res_r;
  logic [31:0]        rem_r;
  logic [32:0]        sh_r;
  logic [5:0]         cnt_r;
  logic [1:0]         phase_r;
  logic [31:0]        q1_r;
  logic [31:0]        qq_r;
  logic [31:0]        rr_r;
  logic [31:0]        dq_r;
  logic [31:0]        frac_r;
  logic               clamped_r;
  logic signed [31:0] yl_r;
  logic signed [31:0] yr_r;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic [63:0]        prod_r;

  // Memories
  logic signed [31:0] smem [DEPTH];
  logic signed [31:0] xmem [DEPTH];
  logic signed [31:0] s_q;
  logic signed [31:0] x_q;

  // Combinational
  logic               in_acc;
  logic               cfg_acc;
  logic [31:0]        st_use;
  logic [31:0]        cnt32;
  logic [CW-1:0]      n_use;
  logic [CW-1:0]      top;
  logic [AW-1:0]      rd_addr;
  logic               s_we;
  logic               x_we;
  logic signed [31:0] run_nxt;
  logic signed [31:0] tbl;
  logic [32:0]        trial;
  logic               ge;
  logic [31:0]        rem_nxt;
  logic [32:0]        quot;
  logic               div_last;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic signed [32:0] delta;
  logic [32:0]        delta_abs;
  logic [64:0]        m_full;
  logic [34:0]        m_cap;
  logic signed [35:0] yl_x;
  logic signed [35:0] m_x;
  logic signed [35:0] res36;
  logic signed [31:0] lin_res;
  logic               below;
  logic               above;

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign in_acc     = in_valid && in_ready;
  assign cfg_acc    = cfg_valid && cfg_ready;

  // Effective step and sample count
  assign st_use = (step_r == 32'd0) ? 32'd1 : step_r;
  always_comb begin
    cnt32 = 32'(count_r);
    if (cnt32 < 32'd2) cnt32 = 32'd2;
    if (cnt32 > DEPTH) cnt32 = DEPTH;
    n_use = CW'(cnt32);
  end
  assign top = n_use - CW'(2);

  assign above = (t_r > end_r);
  assign below = (t_r < start_r);

  // Memory write enables and read address
  assign s_we    = in_acc && (in_op == OP_LOAD) && (32'(in_index) < DEPTH);
  assign run_nxt = (s_q > run_r) ? s_q : run_r;
  assign x_we    = (state_r == S_RBWR);
  assign tbl     = (op_r == OP_BOUND) ? x_q : s_q;

  always_comb begin
    unique case (state_r)
      S_RBRD:  rd_addr = k_r;
      S_RDR:   rd_addr = i_r + AW'(1);
      default: rd_addr = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[AW'(in_index)] <= in_sample;
    s_q <= smem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (x_we) xmem[k_r] <= run_nxt;
    x_q <= xmem[rd_addr];
  end

  // One restoring division step
  assign trial    = {rem_r, sh_r[32]};
  assign ge       = (trial >= {1'b0, st_use});
  assign rem_nxt  = ge ? 32'(trial - {1'b0, st_use}) : trial[31:0];
  assign quot     = {sh_r[31:0], ge};
  assign div_last = (cnt_r == 6'(DIV_STEPS - 1));

  // Shared multiplier operands
  always_comb begin
    unique case (state_r)
      S_CLAMP: begin mul_a = 32'(top); mul_b = st_use; end
      S_MULR:  begin mul_a = mag_r;    mul_b = rr_r;   end
      default: begin mul_a = mag_r;    mul_b = qq_r;   end
    endcase
  end

  // Linear blend and saturation
  assign delta     = {yr_r[31], yr_r} - {yl_r[31], yl_r};
  assign delta_abs = delta[32] ? 33'(-delta) : 33'(delta);
  assign m_full    = {1'b0, prod_r} + 65'(dq_r);
  assign m_cap     = (m_full > 65'h4_0000_0000) ? 35'h4_0000_0000 : m_full[34:0];
  assign yl_x      = {{4{yl_r[31]}}, yl_r};
  assign m_x       = {1'b0, m_cap};
  assign res36     = neg_r ? (yl_x - m_x) : (yl_x + m_x);
  always_comb begin
    if (res36 > 36'sh0_7FFF_FFFF)       lin_res = 32'sh7FFF_FFFF;
    else if (res36 < -36'sh0_8000_0000) lin_res = -32'sh8000_0000;
    else                                lin_res = res36[31:0];
  end

  // Control: sequencer, registers, output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ready_r     <= 1'b0;
      mode_r      <= 2'd0;
      border_r    <= '0;
      start_r     <= '0;
      step_r      <= 32'(1) << FRAC_BITS;
      end_r       <= '0;
      count_r     <= 11'd2;
      const_r     <= 1'b1;
    end else begin
      // drop the result once taken
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_op == OP_VALUE || in_op == OP_BOUND) state_r <= S_DEC;
            else state_r <= S_OUT;
            if (in_op == OP_LOAD) ready_r <= 1'b0;
          end
        end
        S_DEC: begin
          if (const_r) state_r <= S_OUT;
          else if (op_r == OP_BOUND && !ready_r) state_r <= S_RBRD;
          else state_r <= S_CLS;
        end
        S_CLS: begin
          if (above || below) state_r <= S_OUT;
          else state_r <= S_DIV;
        end
        S_RBRD: state_r <= S_RBWR;
        S_RBWR: begin
          if (k_r == '0) begin
            ready_r <= 1'b1;
            state_r <= S_CLS;
          end else begin
            state_r <= S_RBRD;
          end
        end
        S_DIV: begin
          if (div_last) begin
            priority case (phase_r)
              2'd0:    state_r <= S_CLAMP;
              2'd1:    state_r <= S_MULR;
              default: state_r <= S_MULQ;
            endcase
          end
        end
        S_CLAMP: state_r <= (q1_r > 32'(top)) ? S_FRAC : S_RDL;
        S_FRAC:  state_r <= S_RDL;
        S_RDL:   state_r <= S_RDR;
        S_RDR:   state_r <= S_RDW;
        S_RDW:   state_r <= S_MODE;
        S_MODE: begin
          if (mode_r == MODE_HOLD_RIGHT || mode_r == MODE_HOLD_LEFT) state_r <= S_OUT;
          else if (clamped_r) state_r <= S_DIV;
          else state_r <= S_MULR;
        end
        S_MULR: state_r <= S_MDIV;
        S_MDIV: state_r <= S_DIV;
        S_MULQ: state_r <= S_SUM;
        S_SUM:  state_r <= S_OUT;
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // register writes mark the suffix store stale
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_MODE:     begin mode_r   <= cfg_wdata[1:0];  ready_r <= 1'b0; end
          REG_BORDER:   begin border_r <= cfg_wdata;       ready_r <= 1'b0; end
          REG_START:    begin start_r  <= cfg_wdata;       ready_r <= 1'b0; end
          REG_STEP:     begin step_r   <= cfg_wdata;       ready_r <= 1'b0; end
          REG_END:      begin end_r    <= cfg_wdata;       ready_r <= 1'b0; end
          REG_COUNT:    begin count_r  <= cfg_wdata[10:0]; ready_r <= 1'b0; end
          REG_CONSTANT: begin const_r  <= cfg_wdata[0];    ready_r <= 1'b0; end
          default: ;
        endcase
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ready)) out_result_r <= res_r;
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r  <= in_op;
          t_r   <= in_time_req;
          res_r <= '0;
        end
      end
      S_DEC: begin
        res_r <= border_r;
        k_r   <= AW'(n_use - CW'(1));
        run_r <= border_r;
      end
      S_CLS: begin
        off_r <= t_r - start_r;
        if (above) res_r <= border_r;
        else if (below) res_r <= (op_r == OP_BOUND) ? sfx0_r : 32'sd0;
        // start cell division
        rem_r   <= '0;
        sh_r    <= {1'b0, t_r - start_r};
        cnt_r   <= '0;
        phase_r <= 2'd0;
      end
      S_RBRD: ;
      S_RBWR: begin
        run_r <= run_nxt;
        k_r   <= k_r - AW'(1);
        if (k_r == '0) sfx0_r <= run_nxt;
      end
      S_DIV: begin
        rem_r <= rem_nxt;
        sh_r  <= quot;
        cnt_r <= cnt_r + 6'd1;
        if (div_last) begin
          priority case (phase_r)
            2'd0: begin q1_r <= quot[31:0]; rr_r <= rem_nxt; end
            2'd1: begin qq_r <= quot[31:0]; rr_r <= rem_nxt; end
            default: dq_r <= quot[31:0];
          endcase
        end
      end
      S_CLAMP: begin
        prod_r <= mul_a * mul_b;
        if (q1_r > 32'(top)) begin
          clamped_r <= 1'b1;
          i_r       <= AW'(top);
        end else begin
          clamped_r <= 1'b0;
          i_r       <= AW'(q1_r);
          frac_r    <= rr_r;
          qq_r      <= '0;
        end
      end
      S_FRAC: frac_r <= off_r - prod_r[31:0];
      S_RDL:  ;
      S_RDR:  yl_r <= tbl;
      S_RDW:  yr_r <= tbl;
      S_MODE: begin
        mag_r <= delta_abs[31:0];
        neg_r <= delta[32];
        if (mode_r == MODE_HOLD_RIGHT) res_r <= (frac_r == 32'd0) ? yl_r : yr_r;
        else if (mode_r == MODE_HOLD_LEFT) res_r <= (frac_r == st_use) ? yr_r : yl_r;
        // fraction split for the clamped cell
        rem_r   <= '0;
        sh_r    <= {1'b0, frac_r};
        cnt_r   <= '0;
        phase_r <= 2'd1;
      end
      S_MULR: prod_r <= mul_a * mul_b;
      S_MDIV: begin
        rem_r   <= {1'b0, prod_r[63:33]};
        sh_r    <= prod_r[32:0];
        cnt_r   <= '0;
        phase_r <= 2'd2;
      end
      S_MULQ: prod_r <= mul_a * mul_b;
      S_SUM:  res_r <= lin_res;
      S_OUT:  ;
      default: ;
    endcase
  end

endmodule

// ===== design/itsm_checker.sv =====
// Port-level checker for the interpolating table, bound to the top level.
module itsm_checker
  import itsm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_op,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [31:0] out_result
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed or dropped");

  // Empty output after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // One request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Load answers zero into an empty slot
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_LOAD && !out_valid
      |=> ##1 out_valid && out_result == 32'sd0)
    else $error("load result missing or nonzero");

endmodule

bind interpolating_table_with_suffix_max itsm_checker u_itsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_op      (in_op),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_result (out_result)
);
